// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each use clocks on clk_i and is
// switched off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/crbc_pkg.sv =====
`default_nettype none

package crbc_pkg;

  localparam int unsigned ByteW        = 8;
  localparam int unsigned SeedW        = 32;
  localparam int unsigned RotorEntries = 256;
  localparam int unsigned RotorAddrW   = $clog2(RotorEntries);
  localparam int unsigned GenLength    = 15;
  localparam int unsigned SeedBytes    = SeedW / ByteW;

  // Generator taps in the rotating view, where position 0 is the entry about to be updated.
  localparam int unsigned TapA = 9;
  localparam int unsigned TapB = 14;

  // Generator contents on a start; the first four bytes are replaced by the seed.
  localparam logic [ByteW-1:0] GenInit [GenLength] = '{
    8'd0, 8'd0, 8'd0, 8'd0, 8'd56, 8'd34, 8'd199, 8'd77,
    8'd245, 8'd252, 8'd17, 8'd184, 8'd130, 8'd215, 8'd102
  };

  localparam logic [ByteW-1:0] ByteMax = 8'hff;

  // Configuration register indexes.
  localparam logic CfgSeed = 1'b0;
  localparam logic CfgMode = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StFill,
    StSwapJ,
    StSwapK,
    StInv,
    StDrain,
    StRead,
    StResult
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
  } gen_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/crbc_gen.sv =====
`default_nettype none

// Additive lagged generator kept as a rotating register, so that the entry
// being updated and both of its lags always sit at fixed positions.
module crbc_gen (
  input  wire logic                       clk_i,
  input  wire crbc_pkg::gen_ctrl_t        ctrl_i,
  input  wire logic [crbc_pkg::SeedW-1:0] seed_i,
  output logic      [crbc_pkg::ByteW-1:0] value_o
);

  logic [crbc_pkg::ByteW-1:0] buf_q [crbc_pkg::GenLength];
  logic [crbc_pkg::ByteW-1:0] buf_d [crbc_pkg::GenLength];
  logic [crbc_pkg::ByteW-1:0] load_val [crbc_pkg::GenLength];

  assign value_o = buf_q[0] + buf_q[crbc_pkg::TapA] + buf_q[crbc_pkg::TapB];

  // Position k holds generator entry k-1; position 0 holds the last entry.
  always_comb begin
    int src;
    for (int k = 0; k < crbc_pkg::GenLength; k++) begin
      src = (k == 0) ? crbc_pkg::GenLength - 1 : k - 1;
      if (src < crbc_pkg::SeedBytes) begin
        load_val[k] = seed_i[crbc_pkg::ByteW*src +: crbc_pkg::ByteW];
      end else begin
        load_val[k] = crbc_pkg::GenInit[src];
      end
    end
  end

  always_comb begin
    buf_d = buf_q;
    if (ctrl_i.load) begin
      buf_d = load_val;
    end else if (ctrl_i.step) begin
      buf_d[0] = buf_q[crbc_pkg::GenLength-1];
      buf_d[1] = value_o;
      for (int k = 2; k < crbc_pkg::GenLength; k++) begin
        buf_d[k] = buf_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/chained_rotor_byte_cipher.sv =====
`default_nettype none

// Chained rotor byte cipher. Each accepted item carries one byte and returns
// exactly one byte: when encrypting, the byte plus the chained byte indexes
// the forward rotor; when decrypting, the byte indexes the inverse rotor and
// the chained byte is subtracted. In both modes the chain then takes the
// ciphertext byte. An item with start_of_message_i set first rebuilds both
// rotors from the seed register and clears the chain. Both rotors live in
// single-write synchronous memories with a registered read. For an ordinary
// item the accepting edge issues the rotor reads; once the output register is
// free, the result is written into it and the chain is updated. A start item
// first fills the forward rotor with the identity, then performs 510 swaps (a
// swap reads two entries together, then writes them back one after the other
// over the single write port, with the next reads overlapping the second
// write), then builds the inverse rotor and finally does the lookup. A new
// item is accepted while a finished result still waits in the output
// register; its result is held back until that register is free. The seed and
// mode registers should only be written while the block is idle; a new seed
// takes effect at the next start item.
module chained_rotor_byte_cipher (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // configuration port
  input  wire logic                       cfg_we_i,
  input  wire logic                       cfg_index_i,
  input  wire logic [crbc_pkg::SeedW-1:0] cfg_data_i,
  // input channel
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [crbc_pkg::ByteW-1:0] in_byte_i,
  input  wire logic                       start_of_message_i,
  // output channel
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic      [crbc_pkg::ByteW-1:0] out_byte_o
);

  `include "assert_macros.svh"

  localparam int unsigned AW = crbc_pkg::RotorAddrW;
  localparam int unsigned BW = crbc_pkg::ByteW;

  crbc_pkg::state_e state_q, state_d;

  logic [crbc_pkg::SeedW-1:0] seed_q;
  logic                       mode_q;

  // The counter holds the fill index, the swap position j or the inverse index.
  logic [AW-1:0] cnt_q, cnt_d;
  logic          pass_q, pass_d;
  logic [BW-1:0] byte_q, byte_d;
  logic [BW-1:0] chain_q, chain_d;
  logic [AW-1:0] k_q, k_d;
  logic [BW-1:0] dj_q, dj_d;
  logic          inv_pend_q, inv_pend_d;
  logic          out_valid_q, out_valid_d;
  logic [BW-1:0] out_byte_q, out_byte_d;

  crbc_pkg::gen_ctrl_t gen_ctrl;
  logic [BW-1:0]       gen_val;

  // Forward rotor: two read ports, one write port.
  logic [BW-1:0] fwd_mem_q [crbc_pkg::RotorEntries];
  logic          fwd_re, fwd_we;
  logic [AW-1:0] fwd_ra_a, fwd_ra_b, fwd_wa;
  logic [BW-1:0] fwd_wd;
  logic [BW-1:0] fwd_rd_a_q, fwd_rd_b_q, fwd_byp_q;
  logic          fwd_hit_a_q, fwd_hit_b_q;
  logic [BW-1:0] fwd_a_data, fwd_b_data;

  // Inverse rotor: one read port, one write port.
  logic [BW-1:0] inv_mem_q [crbc_pkg::RotorEntries];
  logic          inv_re, inv_we;
  logic [AW-1:0] inv_ra, inv_wa;
  logic [BW-1:0] inv_wd;
  logic [BW-1:0] inv_rd_q;

  logic [BW-1:0] result;
  logic [BW-1:0] next_chain;
  logic [AW-1:0] next_j;

  crbc_gen u_gen (
    .clk_i   (clk_i),
    .ctrl_i  (gen_ctrl),
    .seed_i  (seed_q),
    .value_o (gen_val)
  );

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        crbc_pkg::CfgSeed: seed_q <= cfg_data_i;
        crbc_pkg::CfgMode: mode_q <= cfg_data_i[0];
        default:           seed_q <= seed_q;
      endcase
    end
  end

  // Forward rotor memory. A read issued in the same cycle as a write to the
  // same entry takes the written data, so a swap can overlap the next one.
  always_ff @(posedge clk_i) begin
    if (fwd_we) begin
      fwd_mem_q[fwd_wa] <= fwd_wd;
    end
    if (fwd_re) begin
      fwd_rd_a_q  <= fwd_mem_q[fwd_ra_a];
      fwd_rd_b_q  <= fwd_mem_q[fwd_ra_b];
      fwd_hit_a_q <= fwd_we && (fwd_wa == fwd_ra_a);
      fwd_hit_b_q <= fwd_we && (fwd_wa == fwd_ra_b);
      fwd_byp_q   <= fwd_wd;
    end
  end

  assign fwd_a_data = fwd_hit_a_q ? fwd_byp_q : fwd_rd_a_q;
  assign fwd_b_data = fwd_hit_b_q ? fwd_byp_q : fwd_rd_b_q;

  // Inverse rotor memory.
  always_ff @(posedge clk_i) begin
    if (inv_we) begin
      inv_mem_q[inv_wa] <= inv_wd;
    end
    if (inv_re) begin
      inv_rd_q <= inv_mem_q[inv_ra];
    end
  end

  // The inverse is written in the cycle after the forward read that feeds it.
  assign inv_we = inv_pend_q;
  assign inv_wa = fwd_a_data;
  assign inv_wd = cnt_q - AW'(1);

  assign result     = mode_q ? (inv_rd_q - chain_q) : fwd_a_data;
  assign next_chain = mode_q ? byte_q : fwd_a_data;
  assign next_j     = (cnt_q == AW'(1)) ? crbc_pkg::ByteMax : (cnt_q - AW'(1));

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pass_d      = pass_q;
    byte_d      = byte_q;
    chain_d     = chain_q;
    k_d         = k_q;
    dj_d        = dj_q;
    inv_pend_d  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_byte_d  = out_byte_q;
    gen_ctrl    = '0;
    fwd_re      = 1'b0;
    fwd_we      = 1'b0;
    fwd_ra_a    = cnt_q;
    fwd_ra_b    = gen_val;
    fwd_wa      = cnt_q;
    fwd_wd      = cnt_q;
    inv_re      = 1'b0;
    inv_ra      = byte_q;
    in_ready_o  = 1'b0;

    unique case (state_q)
      crbc_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          byte_d = in_byte_i;
          if (start_of_message_i) begin
            chain_d       = '0;
            cnt_d         = '0;
            pass_d        = 1'b0;
            gen_ctrl.load = 1'b1;
            state_d       = crbc_pkg::StFill;
          end else begin
            fwd_re   = 1'b1;
            inv_re   = 1'b1;
            fwd_ra_a = in_byte_i + chain_q;
            inv_ra   = in_byte_i;
            state_d  = crbc_pkg::StResult;
          end
        end
      end

      crbc_pkg::StFill: begin
        fwd_we = 1'b1;
        cnt_d  = cnt_q + AW'(1);
        if (cnt_q == crbc_pkg::ByteMax) begin
          // The last fill write overlaps the reads of the first swap.
          cnt_d         = cnt_q;
          fwd_re        = 1'b1;
          k_d           = gen_val;
          gen_ctrl.step = 1'b1;
          state_d       = crbc_pkg::StSwapJ;
        end
      end

      crbc_pkg::StSwapJ: begin
        fwd_we  = 1'b1;
        fwd_wd  = fwd_b_data;
        dj_d    = fwd_a_data;
        state_d = crbc_pkg::StSwapK;
      end

      crbc_pkg::StSwapK: begin
        fwd_we = 1'b1;
        fwd_wa = k_q;
        fwd_wd = dj_q;
        if (cnt_q == AW'(1) && pass_q) begin
          cnt_d   = '0;
          state_d = crbc_pkg::StInv;
        end else begin
          pass_d        = pass_q || (cnt_q == AW'(1));
          cnt_d         = next_j;
          fwd_re        = 1'b1;
          fwd_ra_a      = next_j;
          k_d           = gen_val;
          gen_ctrl.step = 1'b1;
          state_d       = crbc_pkg::StSwapJ;
        end
      end

      crbc_pkg::StInv: begin
        fwd_re     = 1'b1;
        inv_pend_d = 1'b1;
        cnt_d      = cnt_q + AW'(1);
        if (cnt_q == crbc_pkg::ByteMax) begin
          state_d = crbc_pkg::StDrain;
        end
      end

      crbc_pkg::StDrain: begin
        state_d = crbc_pkg::StRead;
      end

      crbc_pkg::StRead: begin
        fwd_re   = 1'b1;
        inv_re   = 1'b1;
        fwd_ra_a = byte_q + chain_q;
        inv_ra   = byte_q;
        state_d  = crbc_pkg::StResult;
      end

      crbc_pkg::StResult: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_byte_d  = result;
          chain_d     = next_chain;
          state_d     = crbc_pkg::StIdle;
        end
      end

      default: begin
        state_d = crbc_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= crbc_pkg::StIdle;
      cnt_q       <= '0;
      pass_q      <= 1'b0;
      chain_q     <= '0;
      inv_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pass_q      <= pass_d;
      chain_q     <= chain_d;
      inv_pend_q  <= inv_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    k_q        <= k_d;
    dj_q       <= dj_d;
    out_byte_q <= out_byte_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;

  `ASSERT_NEXT(a_plain_item_looks_up, in_valid_i && in_ready_o && !start_of_message_i,
               state_q == crbc_pkg::StResult, "plain item did not go straight to its result")
  `ASSERT_NEXT(a_shuffle_ends, state_q == crbc_pkg::StSwapK && cnt_q == AW'(1) && pass_q,
               state_q == crbc_pkg::StInv && cnt_q == '0, "shuffle did not end after two passes")
  `ASSERT_NEXT(a_result_delivered, state_q == crbc_pkg::StResult && (!out_valid_q || out_ready_i),
               out_valid_q && state_q == crbc_pkg::StIdle, "result not placed in output register")
  `ASSERT_IMPLIES(a_inverse_write_window, inv_pend_q,
                  state_q == crbc_pkg::StInv || state_q == crbc_pkg::StDrain,
                  "inverse rotor written outside its build")

endmodule

`default_nettype wire
